// ----- sv/prepaid_token_credit_controller_defines.svh -----
// assertion macros for the prepaid token credit controller
`ifndef PREPAID_TOKEN_CREDIT_CONTROLLER_DEFINES_SVH
`define PREPAID_TOKEN_CREDIT_CONTROLLER_DEFINES_SVH

// checked outside reset only
`define PTCC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PTCC_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/ptcc_pkg.sv -----
`timescale 1ns / 1ps

package ptcc_pkg;

	// fixed field widths
	localparam int unsigned NOW_W     = 32;
	localparam int unsigned VALUE_W   = 16;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned FAIL_W    = 4;
	localparam int unsigned BLINK_W   = 4;
	localparam int unsigned LED_W     = 2;
	localparam int unsigned STATUS_W  = 2;

	// failure count clamp
	localparam logic [FAIL_W-1:0] MAX_FAILURES = 4'd11;

	// credit arithmetic
	localparam int unsigned SECONDS_PER_DAY = 86400;
	localparam int unsigned LOCK_UNIT_SECS  = 60;
	localparam int unsigned DIVIDEND_W      = 33;
	localparam int unsigned DIV_CNT_W       = $clog2(DIVIDEND_W + 1);

	// input and output tdata widths
	localparam int unsigned IN_DATA_W  = 72;
	localparam int unsigned OUT_DATA_W = 16;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DAY_DIVISOR   = 2'd0,
		REG_SYNC_VALUE    = 2'd1,
		REG_DISABLE_VALUE = 2'd2
	} reg_idx_t;

	// reset values of the registers
	localparam logic [CFG_W-1:0] DAY_DIVISOR_RST   = 16'd1;
	localparam logic [CFG_W-1:0] SYNC_VALUE_RST    = 16'd999;
	localparam logic [CFG_W-1:0] DISABLE_VALUE_RST = 16'd998;

	// request kinds
	localparam logic KIND_TOKEN = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// token status codes
	localparam logic [STATUS_W-1:0] TOK_VALID   = 2'd0;
	localparam logic [STATUS_W-1:0] TOK_INVALID = 2'd1;
	localparam logic [STATUS_W-1:0] TOK_USED    = 2'd2;

	// led codes
	localparam logic [LED_W-1:0] LED_NONE  = 2'd0;
	localparam logic [LED_W-1:0] LED_GREEN = 2'd1;
	localparam logic [LED_W-1:0] LED_RED   = 2'd2;

	// blink patterns
	localparam logic [BLINK_W-1:0] BLINK_NONE    = 4'd0;
	localparam logic [BLINK_W-1:0] BLINK_USED    = 4'd1;
	localparam logic [BLINK_W-1:0] BLINK_CREDIT  = 4'd2;
	localparam logic [BLINK_W-1:0] BLINK_SYNC    = 4'd3;
	localparam logic [BLINK_W-1:0] BLINK_DISABLE = 4'd5;
	localparam logic [BLINK_W-1:0] BLINK_INVALID = 4'd10;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_APPLY,
		ST_FIN
	} state_t;

	// divider request and status
	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [CFG_W-1:0]      divisor;
	} ptcc_div_req_t;

	typedef struct packed {
		logic             done;
		logic [NOW_W-1:0] quotient;
	} ptcc_div_stat_t;

endpackage

// ----- sv/ptcc_div.sv -----
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module ptcc_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ptcc_pkg::ptcc_div_req_t req,
	output ptcc_pkg::ptcc_div_stat_t stat
);
	import ptcc_pkg::*;

	logic [DIVIDEND_W-1:0] quo_q;
	logic [CFG_W-1:0]      rem_q;
	logic [CFG_W-1:0]      div_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [CFG_W:0]   trial;
	logic [CFG_W:0]   diff;
	logic             ge;
	logic [CFG_W-1:0] rem_next;

	// one trial subtraction
	always_comb begin
		trial    = {rem_q, quo_q[DIVIDEND_W-1]};
		diff     = trial - {1'b0, div_q};
		ge       = (trial >= {1'b0, div_q});
		rem_next = ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign stat.done     = done_q;
	assign stat.quotient = quo_q[NOW_W-1:0];

endmodule

// ----- sv/prepaid_token_credit_controller.sv -----
`timescale 1ns / 1ps

// Prepaid token credit controller. One request is taken at a time on the s_ side: a token
// event (s_tuser low) or a status query (s_tuser high), each with the current seconds
// count. Queries, invalid, used, sync and disable tokens pass through the EVAL and FIN states
// before their result goes to the output register; a credit token also passes through DIV
// and APPLY, where it waits on the 33-step serial divider
// that works out value*86400 over the day divisor register. The result sits in an output
// register, so the next request may be taken while it waits on m_tready. Configuration
// writes are taken in any cycle but are meant for idle periods; a divisor of zero acts as
// one. The entry lock is only reported, tokens are not gated on it.
module prepaid_token_credit_controller (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ptcc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ptcc_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// now_seconds[31:0], token_status[33:32], token_value[49:34], activation_count[65:50]
	input  logic [ptcc_pkg::IN_DATA_W-1:0]     s_tdata,
	// kind[0]
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// led_color[1:0], blink_count[5:2], store_request[6], device_active[7],
	// entry_allowed[8], failure_count[12:9]
	output logic [ptcc_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import ptcc_pkg::*;

	state_t state_q, state_next;

	logic [CFG_W-1:0] day_divisor_q, sync_value_q, disable_value_q;

	logic [FAIL_W-1:0] invalid_count_q;
	logic              payg_enabled_q;
	logic [NOW_W-1:0]  active_until_q;
	logic [NOW_W-1:0]  locked_until_q;

	logic                kind_q;
	logic [NOW_W-1:0]    now_q;
	logic [STATUS_W-1:0] status_q;
	logic [VALUE_W-1:0]  value_q;
	logic                odd_q;

	logic [LED_W-1:0]   led_q;
	logic [BLINK_W-1:0] blinks_q;
	logic               store_q;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic              accept, credit, div_start, out_load;
	logic [FAIL_W-1:0] count_inc;
	logic [NOW_W-1:0]  lock_secs;
	logic [NOW_W-1:0]  credit_base;
	logic              dev_active, entry_ok;

	ptcc_div_req_t  div_req;
	ptcc_div_stat_t div_stat;

	// request decode
	always_comb begin
		accept    = s_tvalid && s_tready;
		credit    = (kind_q == KIND_TOKEN) && (status_q == TOK_VALID) &&
			(value_q != sync_value_q) && (value_q != disable_value_q);
		count_inc = (invalid_count_q < MAX_FAILURES) ? invalid_count_q + 1'b1 : MAX_FAILURES;
		lock_secs = NOW_W'(LOCK_UNIT_SECS) << (count_inc - FAIL_W'(2));
		credit_base = (odd_q || (active_until_q >= now_q)) ? active_until_q : now_q;
		credit_base = odd_q ? now_q : credit_base;
		dev_active  = !payg_enabled_q || (active_until_q > now_q);
		entry_ok    = !(locked_until_q > now_q);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		s_tready   = 1'b0;
		div_start  = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_next = ST_EVAL;
			end
			ST_EVAL: begin
				if (credit) begin
					div_start  = 1'b1;
					state_next = ST_DIV;
				end else begin
					state_next = ST_FIN;
				end
			end
			ST_DIV: begin
				if (div_stat.done) state_next = ST_APPLY;
			end
			ST_APPLY: begin
				state_next = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || m_tready) begin
					out_load   = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_divisor_q   <= DAY_DIVISOR_RST;
			sync_value_q    <= SYNC_VALUE_RST;
			disable_value_q <= DISABLE_VALUE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DAY_DIVISOR:   day_divisor_q   <= cfg_data;
				REG_SYNC_VALUE:    sync_value_q    <= cfg_data;
				REG_DISABLE_VALUE: disable_value_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= s_tuser;
			now_q    <= s_tdata[31:0];
			status_q <= s_tdata[33:32];
			value_q  <= s_tdata[49:34];
			odd_q    <= s_tdata[50];
		end
	end

	// indication of the current request
	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL) begin
			led_q    <= LED_NONE;
			blinks_q <= BLINK_NONE;
			store_q  <= 1'b0;
			if (kind_q == KIND_TOKEN) begin
				case (status_q)
					TOK_INVALID: begin
						led_q    <= LED_RED;
						blinks_q <= BLINK_INVALID;
					end
					TOK_USED: begin
						led_q    <= LED_GREEN;
						blinks_q <= BLINK_USED;
					end
					TOK_VALID: begin
						led_q   <= LED_GREEN;
						store_q <= 1'b1;
						if (value_q == sync_value_q) blinks_q <= BLINK_SYNC;
						else if (value_q == disable_value_q) blinks_q <= BLINK_DISABLE;
						else blinks_q <= BLINK_CREDIT;
					end
					default: ;
				endcase
			end
		end
	end

	// credit and lock state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invalid_count_q <= '0;
			payg_enabled_q  <= 1'b1;
			active_until_q  <= '0;
			locked_until_q  <= '0;
		end else begin
			if (state_q == ST_EVAL && kind_q == KIND_TOKEN) begin
				if (status_q == TOK_INVALID) begin
					invalid_count_q <= count_inc;
					if (count_inc > FAIL_W'(2)) locked_until_q <= now_q + lock_secs;
				end else if (status_q == TOK_VALID) begin
					invalid_count_q <= '0;
					if (value_q != sync_value_q && value_q == disable_value_q)
						payg_enabled_q <= 1'b0;
				end
			end
			if (state_q == ST_APPLY) begin
				if (odd_q) payg_enabled_q <= 1'b1;
				active_until_q <= credit_base + div_stat.quotient;
			end
		end
	end

	// credit seconds divider
	assign div_req.start    = div_start;
	assign div_req.dividend = DIVIDEND_W'(value_q) * DIVIDEND_W'(SECONDS_PER_DAY);
	assign div_req.divisor  = (day_divisor_q == '0) ? CFG_W'(1) : day_divisor_q;

	ptcc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {3'b000, invalid_count_q, entry_ok, dev_active, store_q,
				blinks_q, led_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ----- sv/ptcc_checker.sv -----
`timescale 1ns / 1ps
`include "prepaid_token_credit_controller_defines.svh"

// port-level checks
module ptcc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [ptcc_pkg::OUT_DATA_W-1:0] m_tdata
);
	import ptcc_pkg::*;

	`PTCC_ASSERT_ALWAYS(a_rst_no_result, clk, !arst_n |-> !m_tvalid, "result shown in reset")
	`PTCC_ASSERT(a_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
	`PTCC_ASSERT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready |=> !s_tready, "request taken while busy")
	`PTCC_ASSERT(a_store_green, clk, arst_n, m_tvalid && m_tdata[6] |-> m_tdata[1:0] == LED_GREEN, "store without green")
	`PTCC_ASSERT(a_red_fail, clk, arst_n, m_tvalid && m_tdata[1:0] == LED_RED |-> m_tdata[5:2] == BLINK_INVALID && m_tdata[12:9] != 4'd0 && m_tdata[12:9] <= MAX_FAILURES, "bad failure indication")

endmodule

bind prepaid_token_credit_controller ptcc_checker u_ptcc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
